FILE: sv/wspc_pkg.sv
`default_nettype none
package wspc_pkg;

  localparam int WheelCount = 4;
  localparam int WheelIdxW = 2;
  localparam int FracBits = 16;

  localparam logic [1:0] CmdRun = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdHold = 2'd2;
  localparam logic [1:0] CmdHoldAlt = 2'd3;

  localparam logic [1:0] SignZero = 2'd0;
  localparam logic [1:0] SignPos = 2'd1;
  localparam logic [1:0] SignNeg = 2'd2;

  localparam logic [2:0] RegVelScale = 3'd0;
  localparam logic [2:0] RegVelAlpha = 3'd1;
  localparam logic [2:0] RegGainP = 3'd2;
  localparam logic [2:0] RegGainI = 3'd3;
  localparam logic [2:0] RegGainD = 3'd4;
  localparam logic [2:0] RegTickPeriod = 3'd5;
  localparam logic [2:0] RegIntLimit = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] wheel;
    logic signed [31:0] encoder_count;
    logic signed [31:0] speed_target;
  } in_item_t;

  typedef struct packed {
    logic [1:0] wheel_out;
    logic signed [31:0] drive_level;
    logic signed [31:0] speed_estimate;
    logic signed [31:0] raw_speed;
  } out_item_t;

  typedef struct packed {
    logic [30:0] vel_scale;
    logic [16:0] vel_alpha;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [16:0] tick_period;
    logic [30:0] int_limit;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/wspc_mul.sv
`default_nettype none
// Registered 33 by 33 signed multiplier shared by every product of a tick.
module wspc_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
`default_nettype wire

FILE: sv/wspc_cfg.sv
`default_nettype none
module wspc_cfg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_i,
  input  wire logic [2:0] idx_i,
  input  wire logic [31:0] data_i,
  output wspc_pkg::cfg_t  cfg_o
);
  wspc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vel_scale <= 31'd58826;
      cfg_q.vel_alpha <= 17'd9948;
      cfg_q.gain_p <= 32'sd19660800;
      cfg_q.gain_i <= 32'sd65536000;
      cfg_q.gain_d <= 32'sd0;
      cfg_q.tick_period <= 17'd328;
      cfg_q.int_limit <= 31'd214695936;
    end else if (wr_i) begin
      case (idx_i)
        wspc_pkg::RegVelScale: cfg_q.vel_scale <= data_i[30:0];
        wspc_pkg::RegVelAlpha: cfg_q.vel_alpha <= data_i[16:0];
        wspc_pkg::RegGainP: cfg_q.gain_p <= data_i;
        wspc_pkg::RegGainI: cfg_q.gain_i <= data_i;
        wspc_pkg::RegGainD: cfg_q.gain_d <= data_i;
        wspc_pkg::RegTickPeriod: cfg_q.tick_period <= data_i[16:0];
        wspc_pkg::RegIntLimit: cfg_q.int_limit <= data_i[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

FILE: sv/wheel_speed_pid_controller.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  wspc_pkg::in_item_t
// out       output     out_valid_o / out_stall_i wspc_pkg::out_item_t
// cfg       input      cfg_valid_i / cfg_ready_o index and 32-bit data
// The sequencer runs seven products one after another through one registered
// multiplier. Each of the first four products is launched and then captured,
// the three gain products overlap in the multiplier, then the StSum state
// clamps the I term and StOut registers the result.
// Reset clears all wheel state and loads the default register values.
// A new item is taken once the previous result has been handed over.
module wheel_speed_pid_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire wspc_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wspc_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StRaw   = 8'b00000010,
    StFilA  = 8'b00000100,
    StFilB  = 8'b00001000,
    StInt   = 8'b00010000,
    StTerms = 8'b00100000,
    StSum   = 8'b01000000,
    StOut   = 8'b10000000
  } state_e;

  localparam logic signed [65:0] Half = 66'sd1 <<< (wspc_pkg::FracBits - 1);
  localparam logic [16:0] One = 17'd1 << wspc_pkg::FracBits;

  state_e state_q, state_d;
  logic [1:0] ph_q, ph_d;
  wspc_pkg::in_item_t item_q;
  wspc_pkg::cfg_t cfg;
  logic signed [31:0] last_q [wspc_pkg::WheelCount];
  logic signed [31:0] filt_q [wspc_pkg::WheelCount];
  logic signed [31:0] integ_q [wspc_pkg::WheelCount];
  logic signed [31:0] perr_q [wspc_pkg::WheelCount];
  logic [1:0] psign_q [wspc_pkg::WheelCount];
  logic signed [31:0] raw_q, fil_q, err_q, derr_q, kp_q, ki_q, kd_q, int_q;
  logic signed [65:0] acc_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [31:0] step;
  logic out_valid_q;
  wspc_pkg::out_item_t out_q;
  logic [16:0] alpha;
  logic [1:0] w, sg;
  logic hold, clr;

  wspc_cfg u_cfg (
    .clk_i, .rst_ni, .wr_i(cfg_valid_i && cfg_ready_o), .idx_i(cfg_index_i),
    .data_i(cfg_data_i), .cfg_o(cfg)
  );
  wspc_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  assign w = item_q.wheel;
  assign hold = item_q.command[1];
  assign clr = item_q.command != wspc_pkg::CmdRun;
  assign step = item_q.encoder_count - last_q[w];
  assign alpha = (cfg.vel_alpha > One) ? One : cfg.vel_alpha;
  assign sg = (item_q.speed_target > 0) ? wspc_pkg::SignPos
            : ((item_q.speed_target < 0) ? wspc_pkg::SignNeg : wspc_pkg::SignZero);
  assign cfg_ready_o = (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  function automatic logic signed [31:0] rnd(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + Half) >>> wspc_pkg::FracBits;
    return wspc_pkg::sat32(t);
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      StRaw: begin
        ma = {step[31], step};
        mb = {2'b00, cfg.vel_scale};
      end
      StFilA: begin
        ma = {16'd0, alpha};
        mb = {raw_q[31], raw_q};
      end
      StFilB: begin
        ma = {16'd0, One - alpha};
        mb = {filt_q[w][31], filt_q[w]};
      end
      StInt: begin
        ma = {err_q[31], err_q};
        mb = {16'd0, cfg.tick_period};
      end
      StTerms: begin
        case (ph_q)
          2'd0: begin ma = {cfg.gain_p[31], cfg.gain_p}; mb = {err_q[31], err_q}; end
          2'd1: begin ma = {cfg.gain_i[31], cfg.gain_i}; mb = {int_q[31], int_q}; end
          default: begin ma = {cfg.gain_d[31], cfg.gain_d}; mb = {derr_q[31], derr_q}; end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    case (state_q)
      StIdle: if (in_valid_i && !in_stall_o) begin state_d = StRaw; ph_d = '0; end
      StRaw: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin state_d = StFilA; ph_d = '0; end
      end
      StFilA: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin state_d = StFilB; ph_d = '0; end
      end
      StFilB: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin state_d = StInt; ph_d = '0; end
      end
      StInt: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin state_d = StTerms; ph_d = '0; end
      end
      StTerms: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin state_d = StSum; ph_d = '0; end
      end
      StSum: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ph_q <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < wspc_pkg::WheelCount; k++) begin
        last_q[k] <= '0;
        filt_q[k] <= '0;
        integ_q[k] <= '0;
        perr_q[k] <= '0;
        psign_q[k] <= wspc_pkg::SignZero;
      end
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: if (in_valid_i && !in_stall_o) begin
          item_q <= in_data_i;
        end
        StRaw: if (ph_q == 2'd1) begin
          raw_q <= wspc_pkg::sat32(mp);
          last_q[w] <= item_q.encoder_count;
        end
        StFilA: if (ph_q == 2'd1) begin
          acc_q <= mp;
        end
        StFilB: if (ph_q == 2'd1) begin
          fil_q <= wspc_pkg::sat32((acc_q + mp + Half) >>> wspc_pkg::FracBits);
          err_q <= wspc_pkg::sat32(66'(item_q.speed_target)
                   - 66'(wspc_pkg::sat32((acc_q + mp + Half) >>> wspc_pkg::FracBits)));
          filt_q[w] <= wspc_pkg::sat32((acc_q + mp + Half) >>> wspc_pkg::FracBits);
          if (clr) begin
            integ_q[w] <= '0;
            perr_q[w] <= '0;
            psign_q[w] <= wspc_pkg::SignZero;
          end
        end
        StInt: if (ph_q == 2'd1) begin
          int_q <= wspc_pkg::sat32(66'((sg != psign_q[w]) ? 32'sd0 : integ_q[w])
                   + 66'(rnd(mp)));
          derr_q <= wspc_pkg::sat32(66'(err_q) - 66'(perr_q[w]));
        end
        StTerms: begin
          case (ph_q)
            2'd1: kp_q <= rnd(mp);
            2'd2: ki_q <= rnd(mp);
            2'd3: kd_q <= rnd(mp);
            default: ;
          endcase
        end
        StSum: begin
          if (ki_q >= $signed({1'b0, cfg.int_limit})) begin
            ki_q <= $signed({1'b0, cfg.int_limit});
          end else if (ki_q <= -$signed({1'b0, cfg.int_limit})) begin
            ki_q <= -$signed({1'b0, cfg.int_limit});
          end
        end
        StOut: begin
          out_valid_q <= 1'b1;
          out_q.wheel_out <= w;
          out_q.raw_speed <= raw_q;
          out_q.speed_estimate <= fil_q;
          out_q.drive_level <= hold ? 32'sd0
            : wspc_pkg::sat32(66'(kp_q) + 66'(ki_q) + 66'(kd_q));
          if (!hold) begin
            integ_q[w] <= int_q;
            perr_q[w] <= err_q;
            psign_q[w] <= sg;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut)) else $error("stray result");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state code");
endmodule
`default_nettype wire
